// ===== hw/rtl/sesd_pkg.sv =====
// Shared types and constants for the score event stream decoder.
`default_nettype none

package sesd_pkg;

   // Decoder phases, one-hot.
   typedef enum logic [6:0] {
      PH_INIT_DELTA = 7'b0000001,
      PH_EVENT      = 7'b0000010,
      PH_DELTA      = 7'b0000100,
      PH_EXT_NOTE   = 7'b0001000,
      PH_VELOCITY   = 7'b0010000,
      PH_OFF_EXTRA  = 7'b0100000,
      PH_STOPPED    = 7'b1000000
   } phase_type;

   typedef logic [1:0] reason_type;
   localparam reason_type REASON_END       = 2'd0;
   localparam reason_type REASON_RESERVED  = 2'd1;
   localparam reason_type REASON_EXHAUSTED = 2'd2;

   typedef logic [1:0] csr_index_type;
   localparam csr_index_type CSR_VELOCITY_PRESENT  = 2'd0;
   localparam csr_index_type CSR_OFF_EXTRA_PRESENT = 2'd1;
   localparam csr_index_type CSR_TRANSPOSE         = 2'd2;

   localparam int CSR_DATA_W  = 8;
   localparam int NOTE_W      = 8;
   localparam int TICK_W      = 32;
   localparam int DELTA_W     = 24;
   localparam int GROUP_W     = 6;
   localparam int RSP_TDATA_W = 48;

   localparam logic [GROUP_W-1:0] SUB_STOP     = 6'h3E;
   localparam logic [GROUP_W-1:0] SUB_EXTENDED = 6'h3F;

   typedef struct packed {
      logic              mode;
      logic [7:0]        score_byte;
      logic              last_byte;
   } item_type;

   typedef struct packed {
      logic              velocity_present;
      logic              off_extra_present;
      logic [7:0]        transpose;
   } cfg_type;

   typedef struct packed {
      logic              valid;
      logic              note_valid;
      logic [NOTE_W-1:0] note;
      logic [TICK_W-1:0] due_tick;
      logic              stopped;
      reason_type        stop_reason;
   } result_type;

endpackage

`default_nettype wire

// ===== hw/rtl/sesd_in_stage.sv =====
// Input register stage holding one accepted request beat.
`default_nettype none

module sesd_in_stage (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              in_valid,
   output logic                   in_ready,
   input  wire sesd_pkg::item_type in_item,
   input  wire logic              take,
   output logic                   held_valid,
   output sesd_pkg::item_type     held_item
);
   import sesd_pkg::*;

   logic     valid_ff, valid_in;
   item_type item_ff;

   assign in_ready   = !valid_ff || take;
   assign held_valid = valid_ff;
   assign held_item  = item_ff;

   always_comb begin
      valid_in = valid_ff;
      if (in_valid && in_ready) begin
         valid_in = 1'b1;
      end else if (take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         item_ff <= in_item;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/sesd_parser.sv =====
// Score parser: decoder state and the per-beat decode of one score byte.
`default_nettype none

module sesd_parser (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               fire,
   input  wire sesd_pkg::item_type item,
   input  wire sesd_pkg::cfg_type  cfg,
   output sesd_pkg::result_type    result
);
   import sesd_pkg::*;

   phase_type           phase_ff, phase_in;
   logic [DELTA_W-1:0]  accum_ff, accum_in;
   logic [1:0]          groups_ff, groups_in;
   logic [TICK_W-1:0]   tick_ff, tick_in;
   logic                pend_on_ff, pend_on_in;
   logic [NOTE_W-1:0]   pend_note_ff, pend_note_in;

   logic [GROUP_W-1:0]  grp;
   logic [DELTA_W-1:0]  shifted;
   logic [DELTA_W-1:0]  accum_or;
   logic [TICK_W-1:0]   tick_sum;
   logic                delta_done;

   assign grp        = item.score_byte[GROUP_W-1:0];
   assign accum_or   = accum_ff | shifted;
   assign tick_sum   = tick_ff + {{(TICK_W-DELTA_W){1'b0}}, accum_or};
   assign delta_done = !item.score_byte[6] || (groups_ff == 2'd3);

   // Place the 6-bit group at its position, least significant group first.
   always_comb begin
      case (groups_ff)
         2'd0:    shifted = {18'b0, grp};
         2'd1:    shifted = {12'b0, grp, 6'b0};
         2'd2:    shifted = {6'b0, grp, 12'b0};
         default: shifted = {grp, 18'b0};
      endcase
   end

   always_comb begin
      logic              do_delta;
      logic              do_finish;
      logic              fin_on;
      logic [NOTE_W-1:0] fin_note;
      logic              emit;
      logic [NOTE_W-1:0] emit_src;
      logic              stop;
      reason_type        reason;

      phase_in     = phase_ff;
      accum_in     = accum_ff;
      groups_in    = groups_ff;
      tick_in      = tick_ff;
      pend_on_in   = pend_on_ff;
      pend_note_in = pend_note_ff;
      do_delta     = 1'b0;
      do_finish    = 1'b0;
      fin_on       = pend_on_ff;
      fin_note     = item.score_byte;
      emit         = 1'b0;
      emit_src     = pend_note_ff;
      stop         = 1'b0;
      reason       = REASON_END;
      result       = '0;

      if (!item.mode) begin
         // Start of a new score clears the decoder.
         phase_in     = PH_INIT_DELTA;
         accum_in     = '0;
         groups_in    = '0;
         tick_in      = '0;
         pend_on_in   = 1'b0;
         pend_note_in = '0;
      end else begin
         unique case (phase_ff)
            PH_INIT_DELTA, PH_DELTA: begin
               do_delta = 1'b1;
            end
            PH_EVENT: begin
               if (item.score_byte[7]) begin
                  pend_on_in = item.score_byte[6];
                  if (grp == SUB_STOP) begin
                     stop   = 1'b1;
                     reason = item.score_byte[6] ? REASON_RESERVED : REASON_END;
                  end else if (grp == SUB_EXTENDED) begin
                     phase_in = PH_EXT_NOTE;
                  end else begin
                     pend_note_in = {2'b0, grp};
                     do_finish    = 1'b1;
                     fin_on       = item.score_byte[6];
                     fin_note     = {2'b0, grp};
                  end
               end else begin
                  do_delta = 1'b1;
               end
            end
            PH_EXT_NOTE: begin
               pend_note_in = item.score_byte;
               do_finish    = 1'b1;
            end
            PH_VELOCITY: begin
               emit     = 1'b1;
               phase_in = PH_EVENT;
            end
            PH_OFF_EXTRA: begin
               phase_in = PH_EVENT;
            end
            PH_STOPPED: begin
            end
            default: begin
            end
         endcase

         if (do_delta) begin
            // A delta that ends here, or is cut short by the last byte, is
            // folded into the event time.
            if (delta_done || item.last_byte) begin
               tick_in   = tick_sum;
               accum_in  = '0;
               groups_in = '0;
            end else begin
               accum_in  = accum_or;
               groups_in = groups_ff + 2'd1;
            end
            phase_in = delta_done ? PH_EVENT : PH_DELTA;
         end

         if (do_finish) begin
            if (fin_on) begin
               if (cfg.velocity_present) begin
                  phase_in = PH_VELOCITY;
               end else begin
                  emit     = 1'b1;
                  emit_src = fin_note;
                  phase_in = PH_EVENT;
               end
            end else begin
               phase_in = cfg.off_extra_present ? PH_OFF_EXTRA : PH_EVENT;
            end
         end

         if (phase_ff != PH_STOPPED) begin
            if (!stop && item.last_byte) begin
               stop   = 1'b1;
               reason = REASON_EXHAUSTED;
            end
            if (stop) begin
               phase_in = PH_STOPPED;
            end
            result.valid       = emit || stop;
            result.note_valid  = emit;
            result.note        = emit ? (emit_src - cfg.transpose) : '0;
            result.due_tick    = emit ? tick_ff : '0;
            result.stopped     = stop;
            result.stop_reason = stop ? reason : REASON_END;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_STOPPED;
         accum_ff     <= '0;
         groups_ff    <= '0;
         tick_ff      <= '0;
         pend_on_ff   <= 1'b0;
         pend_note_ff <= '0;
      end else if (fire) begin
         phase_ff     <= phase_in;
         accum_ff     <= accum_in;
         groups_ff    <= groups_in;
         tick_ff      <= tick_in;
         pend_on_ff   <= pend_on_in;
         pend_note_ff <= pend_note_in;
      end
   end

   // A start beat always leaves the parser waiting for the leading delta.
   assert property (@(posedge clock) disable iff (reset)
      fire && !item.mode |=> phase_ff == PH_INIT_DELTA)
      else $error("start beat did not reset the parse phase");

   // Any stop result parks the parser until the next start beat.
   assert property (@(posedge clock) disable iff (reset)
      fire && result.stopped |=> phase_ff == PH_STOPPED)
      else $error("parser kept running after a stop result");

   // Partial delta state only exists while a delta is being collected.
   assert property (@(posedge clock) disable iff (reset)
      groups_ff != 2'd0 |-> phase_ff == PH_DELTA)
      else $error("delta groups pending outside the delta phase");

endmodule

`default_nettype wire

// ===== hw/rtl/sesd_out_stage.sv =====
// Result register stage driving the response beat.
`default_nettype none

module sesd_out_stage (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 load,
   input  wire sesd_pkg::result_type result,
   input  wire logic                 out_ready,
   output logic                      out_valid,
   output sesd_pkg::result_type      out_result
);
   import sesd_pkg::*;

   logic       valid_ff, valid_in;
   result_type result_ff;

   assign out_valid  = valid_ff;
   assign out_result = result_ff;

   // The parser only advances when this register is empty or being drained.
   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = result.valid;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load && result.valid) begin
         result_ff <= result;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/score_event_stream_decoder_core.sv =====
// Top level of the score event stream decoder.
`default_nettype none

// Flow: an accepted request beat is held in the input register, then decoded
// and written into the response register once that register is free or being
// drained, and its response beat is taken from there.
// Throughput: one score byte per cycle while the response side is ready; the
// parser state update is the loop that sets this rate.
// Reset: synchronous, active high; clears handshake state, the configuration
// registers and the parser, which comes up stopped until a start beat.
module score_event_stream_decoder_core (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // Request channel.
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   input  wire logic [7:0]                        req_tdata,  // [7:0] score_byte
   input  wire logic                              req_tuser,  // [0] mode
   input  wire logic                              req_tlast,  // last_byte
   // Response channel.
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   // [7:0] note, [39:8] due_tick, [41:40] stop_reason, [47:42] zero
   output logic [sesd_pkg::RSP_TDATA_W-1:0]       rsp_tdata,
   output logic                                   rsp_tuser,  // [0] note_valid
   output logic                                   rsp_tlast,  // stopped
   // Configuration write port.
   input  wire logic                              csr_we,
   input  wire sesd_pkg::csr_index_type           csr_addr,
   input  wire logic [sesd_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import sesd_pkg::*;

   item_type   req_item;
   item_type   held_item;
   logic       held_valid;
   logic       proc_fire;
   result_type parse_result;
   result_type out_result;
   cfg_type    cfg_ff, cfg_in;

   // Configuration registers. Writes must arrive only while the block is idle,
   // so the parser always sees a settled value; the user ensures it, unchecked.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_addr)
            CSR_VELOCITY_PRESENT:  cfg_in.velocity_present  = csr_wdata[0];
            CSR_OFF_EXTRA_PRESENT: cfg_in.off_extra_present = csr_wdata[0];
            CSR_TRANSPOSE:         cfg_in.transpose         = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign req_item.mode       = req_tuser;
   assign req_item.score_byte = req_tdata;
   assign req_item.last_byte  = req_tlast;

   // The held beat is decoded when the result register is free, or is being
   // emptied in this same cycle. While a finished result waits on the response
   // side, the input register takes one more beat and then holds it until the
   // result register frees up.
   assign proc_fire = held_valid && (!rsp_tvalid || rsp_tready);

   sesd_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_item    (req_item),
      .take       (proc_fire),
      .held_valid (held_valid),
      .held_item  (held_item)
   );

   sesd_parser u_parser (
      .clock  (clock),
      .reset  (reset),
      .fire   (proc_fire),
      .item   (held_item),
      .cfg    (cfg_ff),
      .result (parse_result)
   );

   sesd_out_stage u_out_stage (
      .clock      (clock),
      .reset      (reset),
      .load       (proc_fire),
      .result     (parse_result),
      .out_ready  (rsp_tready),
      .out_valid  (rsp_tvalid),
      .out_result (out_result)
   );

   assign rsp_tdata = {6'b0, out_result.stop_reason, out_result.due_tick, out_result.note};
   assign rsp_tuser = out_result.note_valid;
   assign rsp_tlast = out_result.stopped;

endmodule

`default_nettype wire

// ===== sim/score_decoder_checker.sv =====
// Checker for the score event stream decoder: predicts note and stop beats and compares them.
`timescale 1ns / 1ps

module score_decoder_checker (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_tvalid,
   input  wire logic                            req_tready,
   input  wire logic [7:0]                      req_tdata,
   input  wire logic                            req_tuser,
   input  wire logic                            req_tlast,
   input  wire logic                            rsp_tvalid,
   input  wire logic                            rsp_tready,
   input  wire logic [sesd_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   input  wire logic                            rsp_tuser,
   input  wire logic                            rsp_tlast,
   input  wire logic                            csr_we,
   input  wire sesd_pkg::csr_index_type         csr_addr,
   input  wire logic [sesd_pkg::CSR_DATA_W-1:0] csr_wdata,
   output int                                   failures,
   output int                                   pending
);
   import sesd_pkg::*;

   typedef struct packed {
      logic              note_valid;
      logic [NOTE_W-1:0] note;
      logic [TICK_W-1:0] due_tick;
      logic              stopped;
      reason_type        stop_reason;
   } note_beat_type;

   note_beat_type predicted_beats[$];

   // Shadow copy of the configuration registers.
   logic              cfg_velocity;
   logic              cfg_off_extra;
   logic [7:0]        cfg_transpose;

   // Shadow copy of the parser.
   phase_type         phase;
   logic [DELTA_W-1:0] delta_acc;
   logic [2:0]        groups;
   logic [TICK_W-1:0] event_tick;
   logic              pend_on;
   logic [NOTE_W-1:0] pend_note;

   initial begin
      failures = 0;
      pending  = 0;
   end

   function void clear_score();
      delta_acc  = '0;
      groups     = '0;
      event_tick = '0;
      pend_on    = 1'b0;
      pend_note  = '0;
   endfunction

   // One 6-bit delta group; a clear continuation bit or the fourth group ends the delta.
   function void add_group(input logic [7:0] b);
      delta_acc = delta_acc | ({18'b0, b[5:0]} << (6 * groups[1:0]));
      groups    = groups + 3'd1;
      if (!b[6] || groups >= 3'd4) begin
         event_tick = event_tick + {8'b0, delta_acc};
         delta_acc  = '0;
         groups     = '0;
         phase      = PH_EVENT;
      end else begin
         phase = PH_DELTA;
      end
   endfunction

   function logic [NOTE_W-1:0] fire_note();
      phase = PH_EVENT;
      return pend_note - cfg_transpose;
   endfunction

   function void finish_event(output logic emit, output logic [NOTE_W-1:0] nval);
      emit = 1'b0;
      nval = '0;
      if (pend_on) begin
         if (cfg_velocity) begin
            phase = PH_VELOCITY;
         end else begin
            emit = 1'b1;
            nval = fire_note();
         end
      end else begin
         phase = cfg_off_extra ? PH_OFF_EXTRA : PH_EVENT;
      end
   endfunction

   function void decode_byte(input item_type it, output logic has_beat,
                             output note_beat_type nb);
      logic              stop;
      reason_type        why;
      logic              emit;
      logic [NOTE_W-1:0] nval;
      logic [7:0]        b;
      stop     = 1'b0;
      why      = REASON_END;
      emit     = 1'b0;
      nval     = '0;
      has_beat = 1'b0;
      nb       = '0;
      b        = it.score_byte;
      if (!it.mode) begin
         clear_score();
         phase = PH_INIT_DELTA;
         return;
      end
      if (phase == PH_STOPPED)
         return;
      case (phase)
         PH_INIT_DELTA, PH_DELTA: begin
            add_group(b);
         end
         PH_EVENT: begin
            if (b[7]) begin
               pend_on = b[6];
               if (b[5:0] == SUB_STOP) begin
                  stop = 1'b1;
                  why  = pend_on ? REASON_RESERVED : REASON_END;
               end else if (b[5:0] == SUB_EXTENDED) begin
                  phase = PH_EXT_NOTE;
               end else begin
                  pend_note = {2'b00, b[5:0]};
                  finish_event(emit, nval);
               end
            end else begin
               add_group(b);
            end
         end
         PH_EXT_NOTE: begin
            pend_note = b;
            finish_event(emit, nval);
         end
         PH_VELOCITY: begin
            emit = 1'b1;
            nval = fire_note();
         end
         default: begin
            phase = PH_EVENT;
         end
      endcase
      if (!stop && it.last_byte) begin
         // A delta cut short by the end of the data still counts.
         if (phase == PH_DELTA || phase == PH_INIT_DELTA) begin
            event_tick = event_tick + {8'b0, delta_acc};
            delta_acc  = '0;
            groups     = '0;
         end
         stop = 1'b1;
         why  = REASON_EXHAUSTED;
      end
      if (stop)
         phase = PH_STOPPED;
      if (emit || stop) begin
         has_beat       = 1'b1;
         nb.note_valid  = emit;
         nb.note        = emit ? nval : '0;
         nb.due_tick    = emit ? event_tick : '0;
         nb.stopped     = stop;
         nb.stop_reason = stop ? why : REASON_END;
      end
   endfunction

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         failures++;
         $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin : monitor
      item_type      it;
      note_beat_type got;
      note_beat_type want;
      logic          produced;
      if (reset) begin
         cfg_velocity  = 1'b0;
         cfg_off_extra = 1'b0;
         cfg_transpose = '0;
         clear_score();
         phase = PH_STOPPED;
         predicted_beats.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.note_valid  = rsp_tuser;
            got.note        = rsp_tdata[7:0];
            got.due_tick    = rsp_tdata[39:8];
            got.stop_reason = rsp_tdata[41:40];
            got.stopped     = rsp_tlast;
            if (predicted_beats.size() == 0) begin
               failures++;
               $display("%0t: unexpected response beat, expected none, got %h", $time, got);
            end else begin
               want = predicted_beats.pop_front();
               check_field("note_valid", 32'(want.note_valid), 32'(got.note_valid));
               check_field("note", 32'(want.note), 32'(got.note));
               check_field("due_tick", want.due_tick, got.due_tick);
               check_field("stopped", 32'(want.stopped), 32'(got.stopped));
               check_field("stop_reason", 32'(want.stop_reason), 32'(got.stop_reason));
            end
         end
         if (csr_we) begin
            case (csr_addr)
               CSR_VELOCITY_PRESENT:  cfg_velocity  = csr_wdata[0];
               CSR_OFF_EXTRA_PRESENT: cfg_off_extra = csr_wdata[0];
               CSR_TRANSPOSE:         cfg_transpose = csr_wdata[7:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            it.mode       = req_tuser;
            it.score_byte = req_tdata;
            it.last_byte  = req_tlast;
            decode_byte(it, produced, want);
            if (produced)
               predicted_beats.push_back(want);
         end
      end
      pending = predicted_beats.size();
   end

endmodule

// ===== sim/testbench.sv =====
// Top of the score event stream decoder testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module testbench;
   import sesd_pkg::*;

   // Cycles to let in-flight beats settle after the last expected result; the
   // block passes an accepted request through its input register to the response register.
   localparam int SETTLE_CYCLES = 8;
   // Length of the long receiver hold-off that fills the pipeline.
   localparam int HOLD_CYCLES   = 200;
   // Watchdog; the slowest correct run stays far below this.
   localparam int LIMIT_CYCLES  = 100000;
   // Bytes of random stimulus per configuration phase.
   localparam int PHASE_BEATS   = 175;

   logic                   clock;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [7:0]             req_tdata  = '0;
   logic                   req_tuser  = 1'b0;
   logic                   req_tlast  = 1'b0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   rsp_tuser;
   logic                   rsp_tlast;
   logic                   csr_we     = 1'b0;
   csr_index_type          csr_addr   = CSR_VELOCITY_PRESENT;
   logic [CSR_DATA_W-1:0]  csr_wdata  = '0;

   int failures;
   int pending;

   // Idle and stall percentages for the current phase, and the long hold-off
   // handshake between the stimulus and the receiver process.
   int send_idle_pct = 0;
   int stall_pct     = 0;
   int hold_asked    = 0;
   int hold_served   = 0;
   int hold_left     = 0;

   int cycles     = 0;
   int beats_sent = 0;

   // The stimulus keeps its own view of the two skip flags so that it can
   // build well-formed scores for the current setting.
   logic vel_on = 1'b0;
   logic off_on = 1'b0;

   // Bytes of the score being assembled before it is sent.
   item_type score_q[$];

   score_event_stream_decoder_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),  // [7:0] score_byte
      .req_tuser  (req_tuser),  // [0] mode
      .req_tlast  (req_tlast),  // last_byte
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),  // [7:0] note, [39:8] due_tick, [41:40] stop_reason
      .rsp_tuser  (rsp_tuser),  // [0] note_valid
      .rsp_tlast  (rsp_tlast),  // stopped
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   score_decoder_checker checker_i (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .failures   (failures),
      .pending    (pending)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Watchdog: a hung handshake ends the run as a failure.
   always @(posedge clock) begin
      cycles++;
      if (cycles >= LIMIT_CYCLES) begin
         $display("status: fail");
         $finish;
      end
   end

   // Receiver. It stalls at random with the phase's percentage, and when the
   // stimulus asks for it, holds off for a long stretch that it counts itself
   // while the sender keeps offering beats.
   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_tready = 1'b0;
         hold_left--;
      end else if (hold_served != hold_asked) begin
         hold_served++;
         hold_left  = HOLD_CYCLES - 1;
         rsp_tready = 1'b0;
      end else begin
         rsp_tready = ($urandom_range(99) >= stall_pct);
      end
   end

   function automatic item_type make_beat(input logic m, input logic [7:0] b, input logic l);
      return {m, b, l};
   endfunction

   // Offers one beat, with random idle cycles in front of it, and returns at
   // the falling edge after the handshake. Every task here starts and ends on
   // a falling edge, so inputs only ever change there.
   task automatic send_beat(input item_type b);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tuser  = b.mode;
      req_tdata  = b.score_byte;
      req_tlast  = b.last_byte;
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      @(negedge clock);
      beats_sent++;
   endtask

   task automatic send_score();
      while (score_q.size() > 0)
         send_beat(score_q.pop_front());
      req_tvalid = 1'b0;
   endtask

   // Waits until every predicted beat has come back, then lets the pipeline
   // settle so that bytes that make no result are also through.
   task automatic wait_idle();
      req_tvalid = 1'b0;
      while (pending != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [CSR_DATA_W-1:0] value);
      csr_we    = 1'b1;
      csr_addr  = idx;
      csr_wdata = value;
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   task automatic set_config(input logic vel, input logic off, input logic [7:0] shift);
      wait_idle();
      write_reg(CSR_VELOCITY_PRESENT, {7'b0, vel});
      write_reg(CSR_OFF_EXTRA_PRESENT, {7'b0, off});
      write_reg(CSR_TRANSPOSE, shift);
      vel_on = vel;
      off_on = off;
   endtask

   // Appends a delta of one to four groups. Inside a score the first group
   // must have bit 7 clear or it would read as an event; after that, and in
   // the leading delta, bit 7 is free. A fourth group may still carry the
   // continuation bit, which the block must ignore.
   task automatic push_delta(input logic leading);
      int         ngroups;
      int         g;
      logic [7:0] b;
      ngroups = $urandom_range(1, 4);
      for (g = 0; g < ngroups; g++) begin
         b[5:0] = 6'($urandom);
         b[6]   = (g < ngroups - 1) ? 1'b1 : ((g == 3) ? 1'($urandom) : 1'b0);
         b[7]   = (leading || g > 0) ? 1'($urandom) : 1'b0;
         score_q.push_back(make_beat(1'b1, b, 1'b0));
      end
   endtask

   // Builds and sends one score. Most are well formed with random content:
   // a start beat, a leading delta and a run of note-on and note-off events
   // in both forms, with their skipped bytes where the setting asks for them.
   // A score ends at an end marker, a reserved code, a last byte flag put on
   // some random byte (which can cut a delta or an event short and leaves the
   // rest of the bytes to be ignored), or not at all, so that the next start
   // beat clears a decoder that is still running. A few are plain noise.
   task automatic play_score();
      int         n_events;
      int         ending;
      int         idx;
      logic       on;
      logic [7:0] b;
      item_type   cut;
      if ($urandom_range(9) == 0) begin
         repeat ($urandom_range(1, 8))
            score_q.push_back(make_beat($urandom_range(7) != 0, 8'($urandom),
                                        $urandom_range(7) == 0));
      end else begin
         score_q.push_back(make_beat(1'b0, 8'($urandom), 1'($urandom)));
         push_delta(1'b1);
         n_events = $urandom_range(1, 10);
         repeat (n_events) begin
            if ($urandom_range(1) == 1)
               push_delta(1'b0);
            on = 1'($urandom);
            if ($urandom_range(2) == 0) begin
               score_q.push_back(make_beat(1'b1, {1'b1, on, SUB_EXTENDED}, 1'b0));
               score_q.push_back(make_beat(1'b1, 8'($urandom), 1'b0));
            end else begin
               b = {1'b1, on, 6'($urandom_range(0, 61))};
               score_q.push_back(make_beat(1'b1, b, 1'b0));
            end
            if ((on && vel_on) || (!on && off_on))
               score_q.push_back(make_beat(1'b1, 8'($urandom), 1'b0));
         end
         ending = $urandom_range(9);
         if (ending < 4) begin
            score_q.push_back(make_beat(1'b1, {2'b10, SUB_STOP}, 1'($urandom)));
         end else if (ending == 4) begin
            score_q.push_back(make_beat(1'b1, {2'b11, SUB_STOP}, 1'($urandom)));
         end else if (ending < 9) begin
            idx = ($urandom_range(1) == 1) ? score_q.size() - 1
                                           : $urandom_range(1, score_q.size() - 1);
            cut = score_q[idx];
            cut.last_byte = 1'b1;
            score_q[idx] = cut;
         end
      end
      send_score();
   endtask

   task automatic run_phase(input logic vel, input logic off, input logic [7:0] shift,
                            input int idle, input int stall, input logic long_hold);
      int first;
      set_config(vel, off, shift);
      send_idle_pct = idle;
      stall_pct     = stall;
      if (long_hold)
         hold_asked++;
      first = beats_sent;
      while (beats_sent - first < PHASE_BEATS)
         play_score();
   endtask

   initial begin
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed beats with the reset setting (no skipped bytes, no transpose).
      // A data beat before any start is ignored by the stopped decoder, and
      // the start beat's byte and last flag are ignored as well.
      score_q.push_back(make_beat(1'b1, 8'h85, 1'b0));
      score_q.push_back(make_beat(1'b0, 8'hFF, 1'b1));
      // Leading delta of four groups; bit 7 is ignored in every group and the
      // fourth group ends the delta although its continuation bit is set.
      score_q.push_back(make_beat(1'b1, 8'hC5, 1'b0));
      score_q.push_back(make_beat(1'b1, 8'h7F, 1'b0));
      score_q.push_back(make_beat(1'b1, 8'hFF, 1'b0));
      score_q.push_back(make_beat(1'b1, 8'h7F, 1'b0));
      // Direct note-on, direct note-off, extended note-on with the top note,
      // extended note-off with note zero.
      score_q.push_back(make_beat(1'b1, 8'hD5, 1'b0));
      score_q.push_back(make_beat(1'b1, 8'h8A, 1'b0));
      score_q.push_back(make_beat(1'b1, 8'hFF, 1'b0));
      score_q.push_back(make_beat(1'b1, 8'hFF, 1'b0));
      score_q.push_back(make_beat(1'b1, 8'hBF, 1'b0));
      score_q.push_back(make_beat(1'b1, 8'h00, 1'b0));
      // Note-on of note zero, then the reserved code stops the decoder.
      score_q.push_back(make_beat(1'b1, 8'hC0, 1'b0));
      score_q.push_back(make_beat(1'b1, 8'hFE, 1'b0));
      // End marker; its last flag must not change the stop reason.
      score_q.push_back(make_beat(1'b0, 8'h00, 1'b0));
      score_q.push_back(make_beat(1'b1, 8'h00, 1'b0));
      score_q.push_back(make_beat(1'b1, 8'hBE, 1'b1));
      // Data runs out in the middle of a delta, which is still added.
      score_q.push_back(make_beat(1'b0, 8'h00, 1'b0));
      score_q.push_back(make_beat(1'b1, 8'h41, 1'b1));
      // Data runs out before an extended note byte.
      score_q.push_back(make_beat(1'b0, 8'h00, 1'b0));
      score_q.push_back(make_beat(1'b1, 8'h00, 1'b0));
      score_q.push_back(make_beat(1'b1, 8'hFF, 1'b1));
      // A note-on on the last byte is emitted together with the stop.
      score_q.push_back(make_beat(1'b0, 8'h00, 1'b0));
      score_q.push_back(make_beat(1'b1, 8'h80, 1'b0));
      score_q.push_back(make_beat(1'b1, 8'hC1, 1'b1));
      send_score();

      // Phase one: both skip flags on, most negative transpose, no idling on
      // either side, and the long receiver hold-off. A velocity byte that
      // never comes opens the phase.
      set_config(1'b1, 1'b1, 8'h80);
      score_q.push_back(make_beat(1'b0, 8'h00, 1'b0));
      score_q.push_back(make_beat(1'b1, 8'h00, 1'b0));
      score_q.push_back(make_beat(1'b1, 8'hC3, 1'b1));
      send_score();
      run_phase(1'b1, 1'b1, 8'h80, 0, 0, 1'b1);

      // Sender idles often; most positive transpose.
      run_phase(1'b0, 1'b1, 8'h7F, 56, 0, 1'b0);
      // Receiver stalls often.
      run_phase(1'b1, 1'b0, 8'h01, 0, 56, 1'b0);
      // Both sides idle.
      run_phase(1'b0, 1'b0, 8'hFF, 22, 22, 1'b0);
      // A random setting with both sides idling.
      run_phase(1'($urandom), 1'($urandom), 8'($urandom), 22, 22, 1'b0);

      wait_idle();
      if (failures == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
